>>> rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Types, codes and next-state helpers for the command terminator scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

    // Deepest comment nesting tracked; the depth saturates here
    localparam int MAX_DEPTH = 15;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_BSL    = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;

    typedef enum logic [2:0] {
        CL_TERM,
        CL_BSL,
        CL_QUOTE,
        CL_SLASH,
        CL_STAR,
        CL_OTHER
    } char_class_t;

    typedef enum logic [3:0] {
        ST_NORMAL = 4'd0,
        ST_ESC    = 4'd1,
        ST_STRING = 4'd2,
        ST_SLASH  = 4'd3,
        ST_CSTAR  = 4'd5,
        ST_CSTART = 4'd6,
        ST_CBODY  = 4'd7,
        ST_CEND   = 4'd8,
        ST_STRESC = 4'd9,
        ST_END    = 4'd10
    } scan_state_t;

    typedef struct packed {
        logic [7:0] character;
        logic       restart_scan;
    } in_item_t;

    typedef struct packed {
        logic [3:0] lexer_state;
        logic [3:0] nesting_depth;
        logic       comment_opened;
        logic       comment_closed;
        logic       command_done;
    } out_item_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cl;
        if (c == CHAR_SEMI || c == CHAR_DOLLAR) cl = CL_TERM;
        else if (c == CHAR_BSL)                 cl = CL_BSL;
        else if (c == CHAR_QUOTE)               cl = CL_QUOTE;
        else if (c == CHAR_STAR)                cl = CL_STAR;
        else if (c == CHAR_SLASH)               cl = CL_SLASH;
        else                                    cl = CL_OTHER;
        return cl;
    endfunction

    function automatic logic [3:0] from_normal(input char_class_t cl);
        logic [3:0] ns;
        case (cl)
            CL_TERM:  ns = ST_END;
            CL_BSL:   ns = ST_ESC;
            CL_QUOTE: ns = ST_STRING;
            CL_SLASH: ns = ST_SLASH;
            default:  ns = ST_NORMAL;
        endcase
        return ns;
    endfunction

    function automatic logic [3:0] from_comment(input char_class_t cl);
        logic [3:0] ns;
        case (cl)
            CL_SLASH: ns = ST_SLASH;
            CL_STAR:  ns = ST_CSTAR;
            default:  ns = ST_CBODY;
        endcase
        return ns;
    endfunction

endpackage

>>> rtl/command_terminator_scanner.sv
// ----------------------------------------------------------------------------
// command_terminator_scanner
// Byte-wise lexer for command text: escapes, strings, nested comments, ends.
// ----------------------------------------------------------------------------
// One byte per beat, one result per byte. A new byte is taken every cycle
// unless a stalled result holds it back; each accepted byte is registered
// in the input register, then class decode and state transition load its
// result into the result register. The lexer state and comment depth
// advance as a byte moves from the input register into the result
// register, so a stalled result holds back the scan and throughput drops
// only while result_ready is low. Set restart_scan on a byte to clear
// state and depth before that byte.
module command_terminator_scanner (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_ready,
    input  cts_pkg::in_item_t char_item,
    output logic              result_valid,
    input  logic              result_ready,
    output cts_pkg::out_item_t result_item
);
    import cts_pkg::*;

    logic                stage_valid_reg;
    in_item_t            stage_item_reg;
    logic                result_valid_reg;
    out_item_t           result_item_reg;
    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [DEPTH_W-1:0]  depth_next;

    logic                move;
    logic [3:0]          cur_state;
    logic [DEPTH_W-1:0]  cur_depth;
    char_class_t         cl;
    out_item_t           result_next;

    assign move       = stage_valid_reg && (!result_valid_reg || result_ready);
    assign char_ready = !stage_valid_reg || move;

    // Transition logic
    always_comb
    begin
        cur_state = stage_item_reg.restart_scan ? 4'(ST_NORMAL) : state_reg;
        cur_depth = stage_item_reg.restart_scan ? '0 : depth_reg;
        cl        = classify(stage_item_reg.character);

        case (cur_state)
            ST_NORMAL, ST_END: state_next = from_normal(cl);
            ST_ESC:            state_next = ST_NORMAL;
            ST_STRING:
            begin
                if (cl == CL_BSL)        state_next = ST_STRESC;
                else if (cl == CL_QUOTE) state_next = ST_NORMAL;
                else                     state_next = ST_STRING;
            end
            ST_SLASH:
            begin
                if (cl == CL_STAR)       state_next = ST_CSTART;
                else if (cl == CL_TERM)  state_next = ST_END;
                else                     state_next = ST_NORMAL;
            end
            ST_CBODY:          state_next = from_comment(cl);
            ST_CSTART:         state_next = (cl == CL_STAR) ? 4'(ST_CSTAR) : 4'(ST_CBODY);
            ST_CSTAR:          state_next = (cl == CL_SLASH) ? 4'(ST_CEND) : 4'(ST_CBODY);
            ST_CEND:
            begin
                // Leave the comment only once the outermost level has closed
                if (cur_depth == '0) state_next = from_normal(cl);
                else                 state_next = from_comment(cl);
            end
            ST_STRESC:         state_next = ST_STRING;
            default:           state_next = cur_state;  // unreachable codes hold
        endcase

        depth_next = cur_depth;
        if (state_next == ST_CSTART)
        begin
            if (cur_depth < DEPTH_W'(MAX_DEPTH)) depth_next = cur_depth + 1'b1;
        end
        else if (state_next == ST_CEND)
        begin
            if (cur_depth != '0) depth_next = cur_depth - 1'b1;
        end

        result_next.lexer_state    = state_next;
        result_next.nesting_depth  = 4'(depth_next);
        result_next.comment_opened = (state_next == ST_CSTART);
        result_next.comment_closed = (state_next == ST_CEND);
        result_next.command_done   = (state_next == ST_END);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= ST_NORMAL;
            depth_reg        <= '0;
        end
        else
        begin
            if (char_ready)
                stage_valid_reg <= char_valid;
            if (move)
            begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
                depth_reg        <= depth_next;
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
            stage_item_reg <= char_item;
        if (move)
            result_item_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    // A blocked byte stays in the input register untouched
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !move |=> stage_valid_reg && $stable(stage_item_reg))
        else $error("input register lost a stalled byte");

    // Scan state advances only when a result is loaded
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> $stable(state_reg) && $stable(depth_reg))
        else $error("scan state changed without a result");

    // Opening a comment below the limit deepens the nesting by one
    a_depth_inc: assert property (@(posedge clk) disable iff (!rst_n)
        move && !stage_item_reg.restart_scan && state_next == ST_CSTART
            && depth_reg < DEPTH_W'(MAX_DEPTH)
        |=> depth_reg == $past(depth_reg) + 1'b1)
        else $error("comment open did not increment depth");

endmodule
